[design/lsh_pkg.sv]
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants for the 3x3 Laplacian sharpen stream
// Beat formats, line store words, pipeline items and frame-size helpers.
// ----------------------------------------------------------------------------
package lsh_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 11;
	localparam int CFG_W      = 12;
	localparam int GAIN_W     = 15;
	localparam int PROD_W     = 25;

	localparam logic [CFG_W-1:0] RESET_WIDTH    = 12'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT   = 12'd480;
	localparam logic [CFG_W-1:0] RESET_STRENGTH = 12'd256;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_STRENGTH     = 2'd2
	} reg_index_t;

	// channel 2 is red, 1 green, 0 blue
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [10:0] out_column;
		logic [10:0] out_row;
		logic        run_last;
	} out_beat_t;

	typedef struct packed {
		rgb_t older;
		rgb_t newer;
	} lines_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		lines_t           data;
	} line_wr_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             lag;
		logic             sharp;
		logic             rowend;
		logic             lastrow;
	} tag_t;

	typedef struct packed {
		rgb_t px;
		tag_t tag;
	} pix_item_t;

	typedef struct packed {
		rgb_t            center;
		rgb_t            east;
		rgb_t            px;
		logic [2:0][9:0] ring;
		tag_t            tag;
	} win_item_t;

	typedef struct packed {
		rgb_t lag_px;
		rgb_t east;
		rgb_t px;
		tag_t tag;
	} res_item_t;

	function automatic logic [COL_W-1:0] last_col(input logic [CFG_W-1:0] w);
		logic [COL_W-1:0] r;
		if (w == '0) begin
			r = '0;
		end else if (32'(w) > MAX_WIDTH) begin
			r = COL_W'(MAX_WIDTH - 1);
		end else begin
			r = COL_W'(w - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] last_row(input logic [CFG_W-1:0] h);
		logic [ROW_W-1:0] r;
		if (h == '0) begin
			r = '0;
		end else if (32'(h) > MAX_HEIGHT) begin
			r = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			r = ROW_W'(h - 1'b1);
		end
		return r;
	endfunction

	function automatic logic signed [GAIN_W-1:0] center_gain(input logic [CFG_W-1:0] z);
		return GAIN_W'(256) + $signed({z[CFG_W-1], z, 2'b00});
	endfunction

endpackage

[design/lsh_line_store.sv]
// ----------------------------------------------------------------------------
// lsh_line_store: two-row line memory
// One word per column holds the rows r-2 and r-1; registered read port.
// ----------------------------------------------------------------------------
module lsh_line_store (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [lsh_pkg::COL_W-1:0] rd_addr,
	input  lsh_pkg::line_wr_t        wr,
	output lsh_pkg::lines_t          rd_data
);
	import lsh_pkg::*;

	lines_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/lsh_window.sv]
// ----------------------------------------------------------------------------
// lsh_window: line store write-back and 3x3 neighborhood
// Takes the read word, forwards the previous write on a same-column hit,
// shifts the window, writes the rows back and builds the kernel operands.
// ----------------------------------------------------------------------------
module lsh_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  lsh_pkg::pix_item_t acc_item,
	input  lsh_pkg::lines_t    rd_data,
	input  logic               dn_ready,
	output logic               take,
	output lsh_pkg::line_wr_t  wr,
	output logic               s2_valid,
	output lsh_pkg::win_item_t s2_item
);
	import lsh_pkg::*;

	logic      valid_s1;
	pix_item_t item_s1;
	logic      fwd_s1;
	lines_t    fwd_data_s1;
	logic      valid_s2;
	win_item_t item_s2;

	rgb_t      win_q [9];
	rgb_t      nwin  [9];
	lines_t    lines;
	win_item_t nxt;
	logic      rdy2;
	logic      adv1;

	assign rdy2 = !valid_s2 || dn_ready;
	assign take = !valid_s1 || rdy2;
	assign adv1 = valid_s1 && rdy2;

	// the word read in the same cycle as the previous write is stale
	assign lines = fwd_s1 ? fwd_data_s1 : rd_data;

	always_comb begin
		nwin[0] = win_q[1];
		nwin[1] = win_q[2];
		nwin[2] = lines.older;
		nwin[3] = win_q[4];
		nwin[4] = win_q[5];
		nwin[5] = lines.newer;
		nwin[6] = win_q[7];
		nwin[7] = win_q[8];
		nwin[8] = item_s1.px;
	end

	always_comb begin
		wr.en         = adv1;
		wr.addr       = item_s1.tag.col;
		wr.data.older = lines.newer;
		wr.data.newer = item_s1.px;
	end

	always_comb begin
		nxt.center = nwin[4];
		nxt.east   = nwin[5];
		nxt.px     = item_s1.px;
		nxt.tag    = item_s1.tag;
		for (int ch = 0; ch < 3; ch++) begin
			nxt.ring[ch] = 10'(nwin[1][ch]) + 10'(nwin[3][ch])
				+ 10'(nwin[5][ch]) + 10'(nwin[7][ch]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1     <= acc_item;
			fwd_s1      <= valid_s1 && (item_s1.tag.col == acc_item.tag.col);
			fwd_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv1) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= nwin[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= adv1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s2 <= nxt;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_item  = item_s2;

endmodule

[design/lsh_kernel.sv]
// ----------------------------------------------------------------------------
// lsh_kernel: cross-kernel arithmetic
// Registers center*(1+4z) and z*ring per channel, then subtracts and clamps.
// ----------------------------------------------------------------------------
module lsh_kernel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s2_valid,
	input  lsh_pkg::win_item_t                  s2_item,
	input  logic signed [lsh_pkg::GAIN_W-1:0]   gain,
	input  logic signed [lsh_pkg::CFG_W-1:0]    strength,
	input  logic                                em_ready,
	output logic                                dn_ready,
	output logic                                s3_valid,
	output lsh_pkg::res_item_t                  res
);
	import lsh_pkg::*;

	logic                     valid_s3;
	logic signed [PROD_W-1:0] prod_a_s3 [3];
	logic signed [PROD_W-1:0] prod_b_s3 [3];
	rgb_t                     center_s3;
	rgb_t                     east_s3;
	rgb_t                     px_s3;
	tag_t                     tag_s3;

	logic signed [PROD_W-1:0] diff [3];
	rgb_t                     sharp_px;

	assign dn_ready = !valid_s3 || em_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (dn_ready) begin
			valid_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid && dn_ready) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_a_s3[ch] <= $signed({1'b0, s2_item.center[ch]}) * gain;
				prod_b_s3[ch] <= $signed({1'b0, s2_item.ring[ch]}) * strength;
			end
			center_s3 <= s2_item.center;
			east_s3   <= s2_item.east;
			px_s3     <= s2_item.px;
			tag_s3    <= s2_item.tag;
		end
	end

	// negative sums go to zero, the rest drops 8 fraction bits and caps at 255
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			diff[ch] = prod_a_s3[ch] - prod_b_s3[ch];
			if (diff[ch][PROD_W-1]) begin
				sharp_px[ch] = 8'd0;
			end else if (|diff[ch][PROD_W-2:16]) begin
				sharp_px[ch] = 8'd255;
			end else begin
				sharp_px[ch] = diff[ch][15:8];
			end
		end
	end

	always_comb begin
		res.lag_px = tag_s3.sharp ? sharp_px : center_s3;
		res.east   = east_s3;
		res.px     = px_s3;
		res.tag    = tag_s3;
	end

	assign s3_valid = valid_s3;

endmodule

[design/lsh_emit.sv]
// ----------------------------------------------------------------------------
// lsh_emit: result serializer
// Holds one pixel's results and sends them out one beat at a time.
// ----------------------------------------------------------------------------
module lsh_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s3_valid,
	input  lsh_pkg::res_item_t res,
	input  logic               out_ready,
	output logic               em_ready,
	output logic               out_valid,
	output lsh_pkg::out_beat_t out_data
);
	import lsh_pkg::*;

	localparam int LAG_BIT     = 0;
	localparam int ROWEND_BIT  = 1;
	localparam int LASTROW_BIT = 2;

	logic [2:0] mask_q;
	res_item_t  res_q;
	logic       single;
	logic [2:0] load_mask;
	rgb_t       px_sel;

	assign single    = (mask_q & (mask_q - 3'd1)) == 3'd0;
	assign out_valid = |mask_q;
	assign em_ready  = !out_valid || (out_ready && single);

	always_comb begin
		load_mask              = '0;
		load_mask[LAG_BIT]     = res.tag.lag;
		load_mask[ROWEND_BIT]  = res.tag.rowend;
		load_mask[LASTROW_BIT] = res.tag.lastrow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (em_ready) begin
			mask_q <= s3_valid ? load_mask : 3'b000;
		end else if (out_ready) begin
			// drop the beat just sent
			mask_q <= mask_q & (mask_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (em_ready && s3_valid) begin
			res_q <= res;
		end
	end

	always_comb begin
		if (mask_q[LAG_BIT]) begin
			px_sel              = res_q.lag_px;
			out_data.out_column = 11'(res_q.tag.col - 1'b1);
			out_data.out_row    = 11'(res_q.tag.row - 1'b1);
		end else if (mask_q[ROWEND_BIT]) begin
			px_sel              = res_q.east;
			out_data.out_column = 11'(res_q.tag.col);
			out_data.out_row    = 11'(res_q.tag.row - 1'b1);
		end else begin
			px_sel              = res_q.px;
			out_data.out_column = 11'(res_q.tag.col);
			out_data.out_row    = 11'(res_q.tag.row);
		end
		out_data.out_red   = px_sel[2];
		out_data.out_green = px_sel[1];
		out_data.out_blue  = px_sel[0];
		out_data.run_last  = single;
	end

endmodule

[design/laplacian_sharpen_3x3_stream.sv]
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_stream: 3x3 Laplacian sharpen of an RGB888 stream
// Raster-order pixels in, sharpened or passed-through pixels with coordinates
// out, one row and one column behind.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output keeps up. Each pixel
// produces zero to three result beats, sent one per clock while out_ready is
// high, so a pixel at the end of a row or in the last row can hold the input
// back; row 0 produces none unless it is also the last row. The first
// result of a pixel goes through the line store read, window update and
// write-back, multiply, then clamp into the output register. The two
// previous rows live in one line memory, one word per column, with one read port
// and one write port; the write of the previous pixel is forwarded when
// both hit the same column (one-pixel-wide frames). The memory needs no
// clearing after reset. Writing frame_width or frame_height restarts the
// frame at column 0, row 0; write configuration only while the block is idle.
module laplacian_sharpen_3x3_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lsh_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lsh_pkg::out_beat_t              out_data,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [lsh_pkg::CFG_W-1:0]       cfg_data
);
	import lsh_pkg::*;

	logic [COL_W-1:0]         wlast_q;
	logic [ROW_W-1:0]         hlast_q;
	logic signed [CFG_W-1:0]  strength_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;

	logic      acc;
	logic      restart;
	pix_item_t acc_item;
	lines_t    rd_data;
	line_wr_t  wr;
	logic      take;
	logic      dn_ready;
	logic      s2_valid;
	win_item_t s2_item;
	logic      em_ready;
	logic      s3_valid;
	res_item_t res;

	assign in_ready = take;
	assign acc      = in_valid && in_ready;
	assign restart  = cfg_we && (cfg_index == REG_FRAME_WIDTH
		|| cfg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q    <= last_col(RESET_WIDTH);
			hlast_q    <= last_row(RESET_HEIGHT);
			strength_q <= $signed(RESET_STRENGTH);
			gain_q     <= center_gain(RESET_STRENGTH);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					wlast_q <= last_col(cfg_data);
				end
				REG_FRAME_HEIGHT: begin
					hlast_q <= last_row(cfg_data);
				end
				REG_STRENGTH: begin
					strength_q <= $signed(cfg_data);
					gain_q     <= center_gain(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		acc_item.px          = {in_data.in_red, in_data.in_green, in_data.in_blue};
		acc_item.tag.col     = col_q;
		acc_item.tag.row     = row_q;
		acc_item.tag.lag     = (row_q != '0) && (col_q != '0);
		acc_item.tag.sharp   = (row_q[ROW_W-1:1] != '0) && (col_q[COL_W-1:1] != '0);
		acc_item.tag.rowend  = (row_q != '0) && (col_q == wlast_q);
		acc_item.tag.lastrow = (row_q == hlast_q);
	end

	lsh_line_store u_lines (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (col_q),
		.wr      (wr),
		.rd_data (rd_data)
	);

	lsh_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.acc_item (acc_item),
		.rd_data  (rd_data),
		.dn_ready (dn_ready),
		.take     (take),
		.wr       (wr),
		.s2_valid (s2_valid),
		.s2_item  (s2_item)
	);

	lsh_kernel u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_item  (s2_item),
		.gain     (gain_q),
		.strength (strength_q),
		.em_ready (em_ready),
		.dn_ready (dn_ready),
		.s3_valid (s3_valid),
		.res      (res)
	);

	lsh_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3_valid  (s3_valid),
		.res       (res),
		.out_ready (out_ready),
		.em_ready  (em_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_results_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.run_last |=> out_valid)
		else $error("result beats of one pixel were not contiguous");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (col_q == wlast_q) |=> (col_q == '0))
		else $error("column did not wrap at the row end");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (col_q == wlast_q) && (row_q == hlast_q) |=> (row_q == '0))
		else $error("row did not wrap at the frame end");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (col_q != wlast_q) && !cfg_we |=> (col_q == $past(col_q) + 1'b1))
		else $error("column did not advance by one");
`endif

endmodule

[sim/tb_laplacian_sharpen_3x3_stream.sv]
// ----------------------------------------------------------------------------
// tb_laplacian_sharpen_3x3_stream: self-checking bench for the sharpen stream
// Feeds raster pixels through a short table of hand-picked cases and then
// random frames of many sizes and strengths, under three idling mixes and one
// long output stall. Every output beat is checked field by field against an
// in-bench model of the line stores, the 3x3 window and the border rules.
// ----------------------------------------------------------------------------
module tb_laplacian_sharpen_3x3_stream;
	timeunit 1ns;
	timeprecision 1ps;

	import lsh_pkg::*;

	localparam int          SETTLE_CYCLES = 12;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          N_DIRECTED    = 29;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;

	typedef enum logic [1:0] {
		ROW_PIXEL,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        index;
		logic [CFG_W-1:0]  value;
		in_beat_t          pixel;
		logic              typed;
		out_beat_t         result;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_beat_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_beat_t        out_data;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// expectation typed in by the table, travels with the pixel beat
	logic             typed_pending;
	out_beat_t        typed_beat;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_requests = 0;
	int errors = 0;

	directed_row_t directed_rows [N_DIRECTED];

	// sharpen model state
	logic [23:0]      line_two_up [MAX_WIDTH];
	logic [23:0]      line_one_up [MAX_WIDTH];
	logic [23:0]      nbhd [9];
	int unsigned      next_col = 0;
	int unsigned      next_row = 0;
	logic [CFG_W-1:0] width_reg    = RESET_WIDTH;
	logic [CFG_W-1:0] height_reg   = RESET_HEIGHT;
	logic [CFG_W-1:0] strength_reg = RESET_STRENGTH;
	out_beat_t        expected_beats [$];

	laplacian_sharpen_3x3_stream i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [7:0] sharpen_channel(int center, int ring_sum, int z);
		int acc;
		acc = center * (256 + 4 * z) - z * ring_sum;
		if (acc < 0) begin
			return 8'd0;
		end
		if ((acc >>> 8) > 255) begin
			return 8'd255;
		end
		return 8'(acc >>> 8);
	endfunction

	function automatic out_beat_t make_beat(logic [23:0] px, int unsigned col,
	                                        int unsigned row);
		out_beat_t b;
		b.out_red    = px[23:16];
		b.out_green  = px[15:8];
		b.out_blue   = px[7:0];
		b.out_column = 11'(col);
		b.out_row    = 11'(row);
		b.run_last   = 1'b0;
		return b;
	endfunction

	task automatic predict_pixel(input in_beat_t pixel, input logic typed,
	                             input out_beat_t typed_res);
		int unsigned w, h, c, r;
		int          z, i, sh, ring_sum;
		logic [23:0] px, res;
		out_beat_t   beats [$];
		out_beat_t   b;
		w = (width_reg == '0) ? 1 : (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		h = (height_reg == '0) ? 1 : (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		c = next_col;
		r = next_row;
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		px = {pixel.in_red, pixel.in_green, pixel.in_blue};
		z  = int'($signed(strength_reg));

		// shift the window one column left, pull the new column in on the right
		for (i = 0; i < 3; i++) begin
			nbhd[3 * i]     = nbhd[3 * i + 1];
			nbhd[3 * i + 1] = nbhd[3 * i + 2];
		end
		nbhd[2] = line_two_up[c];
		nbhd[5] = line_one_up[c];
		nbhd[8] = px;
		line_two_up[c] = line_one_up[c];
		line_one_up[c] = px;

		if (r >= 1 && c >= 1) begin
			res = nbhd[4];
			if (c >= 2 && r >= 2) begin
				for (i = 0; i < 3; i++) begin
					sh = 8 * i;
					ring_sum = int'(nbhd[1][sh +: 8]) + int'(nbhd[7][sh +: 8])
					         + int'(nbhd[3][sh +: 8]) + int'(nbhd[5][sh +: 8]);
					res[sh +: 8] = sharpen_channel(int'(nbhd[4][sh +: 8]), ring_sum, z);
				end
			end
			beats.push_back(make_beat(res, c - 1, r - 1));
		end
		if (r >= 1 && c == w - 1) begin
			beats.push_back(make_beat(nbhd[5], c, r - 1));
		end
		if (r == h - 1) begin
			beats.push_back(make_beat(px, c, r));
		end
		if (beats.size() > 0) begin
			b = beats.pop_back();
			b.run_last = 1'b1;
			beats.push_back(b);
		end

		if (typed) begin
			expected_beats.push_back(typed_res);
		end else begin
			foreach (beats[k]) expected_beats.push_back(beats[k]);
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		next_col = c;
		next_row = r;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_data;
						next_col  = 0;
						next_row  = 0;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_data;
						next_col   = 0;
						next_row   = 0;
					end
					REG_STRENGTH: begin
						strength_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				predict_pixel(in_data, typed_pending, typed_beat);
			end
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, expected none, got %h", $time, out_data);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					check_field("out_red", want.out_red, out_data.out_red);
					check_field("out_green", want.out_green, out_data.out_green);
					check_field("out_blue", want.out_blue, out_data.out_blue);
					check_field("out_column", want.out_column, out_data.out_column);
					check_field("out_row", want.out_row, out_data.out_row);
					check_field("run_last", want.run_last, out_data.run_last);
				end
			end
		end
	end

	// output side: random idling, plus a long hold when one is requested
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] random_strength();
		if ($urandom_range(0, 1)) begin
			return CFG_W'($urandom_range(0, 4095));
		end
		return CFG_W'($urandom_range(0, 640));
	endfunction

	task automatic send_pixel(in_beat_t px, logic typed, out_beat_t result);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		in_data       <= px;
		typed_pending <= typed;
		typed_beat    <= result;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid, drain every expected beat, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
	                         logic [CFG_W-1:0] z, int items, bit sizes);
		if (sizes) begin
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
		end
		write_reg(REG_STRENGTH, z);
		repeat (items) begin
			send_pixel('{random_channel(), random_channel(), random_channel()}, 1'b0, '0);
		end
	endtask

	// whole frames of random size, some with a partial frame tacked on
	task automatic run_random_phases(int n);
		int unsigned w, h;
		repeat (n) begin
			w = $urandom_range(1, 5);
			h = $urandom_range(2, 3);
			run_phase(CFG_W'(w), CFG_W'(h), random_strength(),
			          w * h + $urandom_range(0, w), 1'b1);
		end
	endtask

	initial begin
		int i;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		typed_pending = 1'b0;
		typed_beat    = '0;
		tx_idle_pct   = 18;
		rx_idle_pct   = 57;
		for (i = 0; i < MAX_WIDTH; i++) begin
			line_two_up[i] = '0;
			line_one_up[i] = '0;
		end
		for (i = 0; i < 9; i++) nbhd[i] = '0;

		directed_rows = '{
			// reset sizes: row 0 of a wide frame gives nothing
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'h00, 8'h80}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'hff, 8'h7f}, 1'b0, '0},
			// height 0 acts as one row: every pixel comes straight back
			'{ROW_WRITE, REG_FRAME_WIDTH, 12'd3, '0, 1'b0, '0},
			'{ROW_WRITE, REG_FRAME_HEIGHT, 12'd0, '0, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b1,
			  '{8'h00, 8'h00, 8'h00, 11'd0, 11'd0, 1'b1}},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'hff, 8'hff}, 1'b1,
			  '{8'hff, 8'hff, 8'hff, 11'd1, 11'd0, 1'b1}},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h5a, 8'ha5, 8'h3c}, 1'b1,
			  '{8'h5a, 8'ha5, 8'h3c, 11'd2, 11'd0, 1'b1}},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h12, 8'h34, 8'h56}, 1'b1,
			  '{8'h12, 8'h34, 8'h56, 11'd0, 11'd0, 1'b1}},
			// 3x3 frame at the most negative strength
			'{ROW_WRITE, REG_FRAME_HEIGHT, 12'd3, '0, 1'b0, '0},
			'{ROW_WRITE, REG_STRENGTH, 12'h800, '0, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h10, 8'h20, 8'h30}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'hff, 8'hff}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'h80, 8'h01}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'hff, 8'hff}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h40, 8'h40, 8'h40}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h80, 8'h80, 8'h80}, 1'b0, '0},
			// same frame shape at the most positive strength
			'{ROW_WRITE, REG_STRENGTH, 12'h7ff, '0, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h01, 8'h02, 8'h03}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'hff, 8'hff}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'hff, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h80, 8'h7f, 8'h01}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'hff, 8'h00, 8'hff}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{ROW_PIXEL, REG_FRAME_WIDTH, 12'd0, '{8'h7f, 8'h7f, 8'h7f}, 1'b0, '0}
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_WRITE) begin
				write_reg(directed_rows[n].index, directed_rows[n].value);
			end else begin
				send_pixel(directed_rows[n].pixel, directed_rows[n].typed,
				           directed_rows[n].result);
			end
		end

		// sender idles now and then, receiver most of the time
		run_phase(12'd5, 12'd4, 12'd256, 21, 1'b1);
		// hold the output off while pixels keep coming, so the input stalls
		run_phase(12'd6, 12'd4, random_strength(), 0, 1'b1);
		hold_requests++;
		repeat (12) begin
			send_pixel('{random_channel(), random_channel(), random_channel()}, 1'b0, '0);
		end
		run_phase(12'd4095, 12'd0, 12'h7ff, 4, 1'b1);
		run_random_phases(1);

		tx_idle_pct = 57;
		rx_idle_pct = 18;
		run_phase(12'd0, 12'd4095, 12'h800, 4, 1'b1);
		run_phase(12'd2, 12'd3, random_strength(), 6, 1'b1);
		run_phase(12'd3, 12'd2, random_strength(), 6, 1'b1);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// unknown index and a strength change mid-frame keep the raster position
		run_phase(12'd5, 12'd4, random_strength(), 7, 1'b1);
		write_reg(REG_UNUSED, 12'hfff);
		run_phase(12'd5, 12'd4, random_strength(), 6, 1'b0);
		run_random_phases(1);

		settle();
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
